// ===== sv/hck_pkg.sv =====
// Package for the HSV chroma keyer with spill suppression.
// Holds pixel and register widths, register indexes and reset values.
// No dependencies; every other file of the block imports it.
package hck_pkg;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HUE_WINDOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_WINDOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAL_WINDOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPILL_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPILL_MARGIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPILL_SAT_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPILL_VAL_MIN = 3'd6;

	// Register reset values: windows open (min 0, max 255)
	localparam logic [CFG_W-1:0] WINDOW_RESET = 16'hFF00;

	// Fixed-point constants
	localparam int FRAC_BITS  = 12;
	localparam int HUE_RANGE  = 180;
	localparam int SAT_SCALE  = 255;
	// floor(x/10) = (x * DIV10_MUL) >> DIV10_SHIFT for x below 4096
	localparam int DIV10_MUL   = 6554;
	localparam int DIV10_SHIFT = 16;
	localparam logic [PIX_W-1:0] ALPHA_KEYED  = 8'd0;
	localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

endpackage

// ===== sv/hck_pix_in_if.sv =====
// Input pixel channel of the chroma keyer: valid, ready and one RGB word.
// Depends on hck_pkg for the pixel width.
interface hck_pix_in_if import hck_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_red;
	logic [PIX_W-1:0] pixel_green;
	logic [PIX_W-1:0] pixel_blue;

	modport source (output valid, output pixel_red, output pixel_green,
		output pixel_blue, input ready);
	modport sink (input valid, input pixel_red, input pixel_green,
		input pixel_blue, output ready);
endinterface

// ===== sv/hck_pix_out_if.sv =====
// Output pixel channel of the chroma keyer: valid, ready and one RGBA word.
// Depends on hck_pkg for the pixel width.
interface hck_pix_out_if import hck_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [PIX_W-1:0] out_alpha;

	modport source (output valid, output out_red, output out_green,
		output out_blue, output out_alpha, input ready);
	modport sink (input valid, input out_red, input out_green,
		input out_blue, input out_alpha, output ready);
endinterface

// ===== sv/hsv_chroma_key_spill_top.sv =====
// Top level of the HSV chroma keyer with green spill suppression.
// Depends on hck_pkg, hck_pix_in_if and hck_pix_out_if.
//
// Usage:
//   pix_in carries one RGB word per handshake, pix_out one RGBA word.
//   A word is taken at a rising edge where valid and ready are both high.
//   Registers are written through cfg_we / cfg_index / cfg_data, one per
//   edge with cfg_we high; write them only while the pipeline is empty.
// Stages and throughput:
//   Five register stages: the HSV front end, the reciprocal tables, the
//   multipliers, rounding and divide by ten, and the window compare with
//   output register. One word enters per cycle while the stages are not
//   all full behind a stalled pix_out.
// Reset:
//   arst_n clears all stage valid bits and loads the register defaults
//   (windows fully open, spill suppression off).
// Stall:
//   Each stage holds its word while the next one is full and stalled; empty
//   stages still fill, so input is accepted until all five stages hold a
//   word behind a stalled receiver. Nothing is dropped or repeated.
module hsv_chroma_key_spill_top import hck_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	hck_pix_in_if.sink           pix_in,
	hck_pix_out_if.source        pix_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [CFG_W-1:0] hue_window_q;
	logic [CFG_W-1:0] sat_window_q;
	logic [CFG_W-1:0] val_window_q;
	logic             spill_enable_q;
	logic [PIX_W-1:0] spill_margin_q;
	logic [PIX_W-1:0] spill_sat_min_q;
	logic [PIX_W-1:0] spill_val_min_q;

	// Write one register per enabled edge; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_window_q    <= WINDOW_RESET;
			sat_window_q    <= WINDOW_RESET;
			val_window_q    <= WINDOW_RESET;
			spill_enable_q  <= 1'b0;
			spill_margin_q  <= '0;
			spill_sat_min_q <= '0;
			spill_val_min_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HUE_WINDOW:    hue_window_q    <= cfg_data;
				REG_SAT_WINDOW:    sat_window_q    <= cfg_data;
				REG_VAL_WINDOW:    val_window_q    <= cfg_data;
				REG_SPILL_ENABLE:  spill_enable_q  <= cfg_data[0];
				REG_SPILL_MARGIN:  spill_margin_q  <= cfg_data[PIX_W-1:0];
				REG_SPILL_SAT_MIN: spill_sat_min_q <= cfg_data[PIX_W-1:0];
				REG_SPILL_VAL_MIN: spill_val_min_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Reciprocal tables, worked out at elaboration:
	// sat_rec[v] = round(255*4096/v), hue_rec[d] = round(180*4096/(6d))
	logic [19:0] sat_rec [256];
	logic [16:0] hue_rec [256];

	for (genvar Idx = 0; Idx < 256; Idx++) begin : g_rec
		localparam int Den = (Idx == 0) ? 1 : Idx;
		localparam int SatRec = (Idx == 0) ? 0 :
			((2 * (SAT_SCALE << FRAC_BITS)) + Den) / (2 * Den);
		localparam int HueRec = (Idx == 0) ? 0 :
			((2 * (HUE_RANGE << FRAC_BITS)) + 6 * Den) / (12 * Den);
		assign sat_rec[Idx] = 20'(SatRec);
		assign hue_rec[Idx] = 17'(HueRec);
	end

	// Stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5 = !vld_s5 || pix_out.ready;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pix_in.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: max, min, chroma and hue sector numerator
	logic [PIX_W-1:0] in_r, in_g, in_b, vmax_c, vmin_c, delta_c;
	logic signed [11:0] hnum_c;

	assign in_r = pix_in.pixel_red;
	assign in_g = pix_in.pixel_green;
	assign in_b = pix_in.pixel_blue;

	always_comb begin
		vmax_c = in_r;
		if (in_g > vmax_c) vmax_c = in_g;
		if (in_b > vmax_c) vmax_c = in_b;
		vmin_c = in_r;
		if (in_g < vmin_c) vmin_c = in_g;
		if (in_b < vmin_c) vmin_c = in_b;
		delta_c = vmax_c - vmin_c;
		if (vmax_c == in_r) begin
			hnum_c = $signed({4'b0, in_g}) - $signed({4'b0, in_b});
		end else if (vmax_c == in_g) begin
			hnum_c = $signed({4'b0, in_b}) - $signed({4'b0, in_r})
				+ $signed({3'b0, delta_c, 1'b0});
		end else begin
			hnum_c = $signed({4'b0, in_r}) - $signed({4'b0, in_g})
				+ $signed({2'b0, delta_c, 2'b0});
		end
	end

	logic [PIX_W-1:0] red_s1, green_s1, blue_s1, vmax_s1, delta_s1;
	logic signed [11:0] hnum_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			red_s1   <= in_r;
			green_s1 <= in_g;
			blue_s1  <= in_b;
			vmax_s1  <= vmax_c;
			delta_s1 <= delta_c;
			hnum_s1  <= hnum_c;
		end
	end

	// Stage 2: table lookups, the green square and the red-blue product for the strong-spill test
	logic [PIX_W-1:0]   red_s2, green_s2, blue_s2, vmax_s2, delta_s2;
	logic signed [11:0] hnum_s2;
	logic [19:0]        srec_s2;
	logic [16:0]        hrec_s2;
	logic [15:0]        gg_s2, rb_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
			vmax_s2  <= vmax_s1;
			delta_s2 <= delta_s1;
			hnum_s2  <= hnum_s1;
			srec_s2  <= sat_rec[vmax_s1];
			hrec_s2  <= hue_rec[delta_s1];
			gg_s2    <= green_s1 * green_s1;
			rb_s2    <= red_s1 * blue_s1;
		end
	end

	// Stage 3: fixed-point products and channel gains
	logic        strong_c;
	logic [3:0]  gain_c;

	assign strong_c = (rb_s2 != 16'd0) &&
		({1'b0, gg_s2, 1'b0} >= ({2'b0, rb_s2} + {1'b0, rb_s2, 1'b0}));
	assign gain_c = strong_c ? 4'd14 : 4'd12;

	logic [PIX_W-1:0]   red_s3, green_s3, blue_s3, vmax_s3;
	logic [27:0]        sprod_s3;
	logic signed [29:0] hprod_s3;
	logic [11:0]        rk_s3, gk_s3, bk_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
			vmax_s3  <= vmax_s2;
			sprod_s3 <= delta_s2 * srec_s2;
			hprod_s3 <= hnum_s2 * $signed({1'b0, hrec_s2});
			rk_s3    <= red_s2 * gain_c;
			bk_s3    <= blue_s2 * gain_c;
			gk_s3    <= green_s2 * 4'd9;
		end
	end

	// Stage 4: round S and H, wrap negative hue, divide gains by ten
	logic [27:0]        sround_c;
	logic signed [29:0] hround_c;
	logic signed [8:0]  hshift_c, hwrap_c;
	logic [24:0]        rq_c, gq_c, bq_c;

	assign sround_c = sprod_s3 + 28'(1 << (FRAC_BITS - 1));
	assign hround_c = hprod_s3 + 30'sd2048;
	assign hshift_c = hround_c[FRAC_BITS+8:FRAC_BITS];
	assign hwrap_c  = (hshift_c < 0) ? hshift_c + 9'sd180 : hshift_c;
	assign rq_c = rk_s3 * 13'(DIV10_MUL);
	assign gq_c = gk_s3 * 13'(DIV10_MUL);
	assign bq_c = bk_s3 * 13'(DIV10_MUL);

	logic [PIX_W-1:0] red_s4, green_s4, blue_s4, vmax_s4, sat_s4, hue_s4;
	logic [8:0]       rdiv_s4, gdiv_s4, bdiv_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			red_s4   <= red_s3;
			green_s4 <= green_s3;
			blue_s4  <= blue_s3;
			vmax_s4  <= vmax_s3;
			sat_s4   <= sround_c[FRAC_BITS+7:FRAC_BITS];
			hue_s4   <= hwrap_c[7:0];
			rdiv_s4  <= rq_c[DIV10_SHIFT+8:DIV10_SHIFT];
			gdiv_s4  <= gq_c[DIV10_SHIFT+8:DIV10_SHIFT];
			bdiv_s4  <= bq_c[DIV10_SHIFT+8:DIV10_SHIFT];
		end
	end

	// Stage 5: key windows, spill decision, saturation, output register
	logic              keyed_c, spill_c;
	logic signed [9:0] hue_lo_c;
	logic [9:0]        hue_hi_c;

	assign keyed_c =
		(hue_s4 >= hue_window_q[7:0])  && (hue_s4 <= hue_window_q[15:8]) &&
		(sat_s4 >= sat_window_q[7:0])  && (sat_s4 <= sat_window_q[15:8]) &&
		(vmax_s4 >= val_window_q[7:0]) && (vmax_s4 <= val_window_q[15:8]);
	assign hue_lo_c = $signed({2'b0, hue_window_q[7:0]}) - $signed({2'b0, spill_margin_q});
	assign hue_hi_c = {2'b0, hue_window_q[15:8]} + {2'b0, spill_margin_q};
	assign spill_c = spill_enable_q &&
		($signed({2'b0, hue_s4}) >= hue_lo_c) && ({2'b0, hue_s4} <= hue_hi_c) &&
		(sat_s4 >= spill_sat_min_q) && (vmax_s4 > spill_val_min_q);

	logic [PIX_W-1:0] red_s5, green_s5, blue_s5, alpha_s5;

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			alpha_s5 <= keyed_c ? ALPHA_KEYED : ALPHA_OPAQUE;
			if (spill_c) begin
				red_s5   <= rdiv_s4[8] ? 8'd255 : rdiv_s4[7:0];
				green_s5 <= gdiv_s4[8] ? 8'd255 : gdiv_s4[7:0];
				blue_s5  <= bdiv_s4[8] ? 8'd255 : bdiv_s4[7:0];
			end else begin
				red_s5   <= red_s4;
				green_s5 <= green_s4;
				blue_s5  <= blue_s4;
			end
		end
	end

	assign pix_out.valid     = vld_s5;
	assign pix_out.out_red   = red_s5;
	assign pix_out.out_green = green_s5;
	assign pix_out.out_blue  = blue_s5;
	assign pix_out.out_alpha = alpha_s5;

	// Checks on the pipeline control and the datapath ranges
	a_alpha_code: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (pix_out.out_alpha == ALPHA_KEYED ||
			pix_out.out_alpha == ALPHA_OPAQUE))
		else $error("alpha is neither keyed nor opaque");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !pix_out.ready)
			|-> !pix_in.ready)
		else $error("input accepted while every stage is full and stalled");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (hue_s4 < 8'(HUE_RANGE)))
		else $error("hue out of range after wrap");

	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && adv_s5) |=> vld_s5)
		else $error("word lost between stage four and the output register");

endmodule
